### design/csqrt_pkg.sv
// ----------------------------------------------------------------------------
// csqrt_pkg
// Shared widths, register indexes and reset values of the CORDIC square-root
// unit.
// ----------------------------------------------------------------------------
package csqrt_pkg;

  localparam int SAMPLE_W = 32;
  localparam int ROOT_W   = 50;
  localparam int COUNT_W  = 5;
  localparam int GAIN_W   = 17;
  localparam int CFG_W    = GAIN_W;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [ROOT_W-1:0]   root_t;
  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [GAIN_W-1:0]   gain_t;
  typedef logic [CFG_W-1:0]    cfg_data_t;

  typedef enum logic [0:0] {
    REG_ITERATION_COUNT = 1'b0,
    REG_GAIN_WORD       = 1'b1
  } cfg_index_t;

  localparam count_t ITERATION_COUNT_RESET = 5'd16;
  localparam gain_t  GAIN_WORD_RESET       = 17'd79135;

endpackage

### design/cordic_square_root_unit.sv
// ----------------------------------------------------------------------------
// cordic_square_root_unit
// Scaled square root by hyperbolic CORDIC vectoring on one shared shift-add
// unit, with even pre-normalization and a final gain multiply.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                    payload
//  sample    in         sample_valid / sample_stall  sample
//  result    out        result_valid / result_stall  root_scaled
//  config    in         cfg_write                    cfg_index, cfg_data
//
//  After the transfer an item passes through the normalization steps (four or
//  two bits a step), the CORDIC iterations (iteration_count plus one per
//  repeated index), an exit check, the denormalizing shift and the multiply.
//  The CORDIC loop runs one iteration a cycle. A zero sample goes straight to
//  the multiply. Reset is synchronous and restores the configuration
//  registers. A stalled result holds the multiply state, while a new sample
//  is taken as soon as the core is idle.
// ----------------------------------------------------------------------------
module cordic_square_root_unit #(
  parameter int WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sample_valid,
  output logic                  sample_stall,
  input  csqrt_pkg::sample_t    sample,
  output logic                  result_valid,
  input  logic                  result_stall,
  output csqrt_pkg::root_t      root_scaled,
  input  logic                  cfg_write,
  input  csqrt_pkg::cfg_index_t cfg_index,
  input  csqrt_pkg::cfg_data_t  cfg_data
);
  import csqrt_pkg::*;

  localparam int XW = WIDTH + 3;
  localparam int UW = WIDTH + 1;
  localparam int PW = XW + GAIN_W + 1;
  localparam logic signed [XW-1:0] QUARTER = {{(XW-1){1'b0}}, 1'b1} << (WIDTH - 2);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NORM,
    ST_ROT,
    ST_SCALE,
    ST_MUL
  } state_t;

  state_t                 state;
  count_t                 iteration_count;
  gain_t                  gain_word;
  logic [UW-1:0]          u_work;
  logic signed [XW-1:0]   x_work;
  logic signed [XW-1:0]   y_work;
  logic [5:0]             shift_index;
  logic [5:0]             next_repeat;
  logic [5:0]             norm_shift;

  logic [WIDTH-1:0]       s_in;
  logic [UW-1:0]          u_fin;
  logic [5:0]             n_fin;
  logic signed [XW-1:0]   u_ext;
  logic signed [XW-1:0]   xs;
  logic signed [XW-1:0]   ys;
  logic signed [XW-1:0]   x_rot;
  logic signed [XW-1:0]   y_rot;
  logic [7:0]             rep_calc;
  logic signed [PW-1:0]   product;
  logic                   out_free;

  assign sample_stall = (state != ST_IDLE);
  assign out_free     = !result_valid || !result_stall;
  assign s_in         = WIDTH'(sample);

  always_comb begin
    // A single leading zero is widened to a shift of two, moving the top bit
    // one place above the sample field.
    if (norm_shift == 6'd0 && !u_work[WIDTH-1]) begin
      u_fin = u_work << 2;
      n_fin = 6'd2;
    end else begin
      u_fin = u_work;
      n_fin = norm_shift;
    end
    u_ext = XW'(u_fin);

    xs = x_work >>> shift_index;
    ys = y_work >>> shift_index;
    if (y_work[XW-1]) begin
      x_rot = x_work + ys;
      y_rot = y_work + xs;
    end else begin
      x_rot = x_work - ys;
      y_rot = y_work - xs;
    end
    rep_calc = {2'b00, shift_index} + {1'b0, shift_index, 1'b0} + 8'd1;

    product = PW'(x_work) * $signed({1'b0, gain_word});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      result_valid    <= 1'b0;
      iteration_count <= ITERATION_COUNT_RESET;
      gain_word       <= GAIN_WORD_RESET;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_ITERATION_COUNT: iteration_count <= cfg_data[COUNT_W-1:0];
          REG_GAIN_WORD:       gain_word       <= cfg_data;
          default:             ;
        endcase
      end

      // The multiply state drives valid itself when it hands over a result.
      if (result_valid && !result_stall && state != ST_MUL) begin
        result_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (sample_valid) begin
            u_work      <= {1'b0, s_in};
            norm_shift  <= 6'd0;
            shift_index <= 6'd1;
            next_repeat <= 6'd4;
            if (s_in == '0) begin
              x_work <= '0;
              y_work <= '0;
              state  <= ST_MUL;
            end else begin
              state <= ST_NORM;
            end
          end
        end

        ST_NORM: begin
          if (u_work[WIDTH-1 -: 4] == 4'd0) begin
            u_work     <= u_work << 4;
            norm_shift <= norm_shift + 6'd4;
          end else if (u_work[WIDTH-1 -: 2] == 2'd0) begin
            u_work     <= u_work << 2;
            norm_shift <= norm_shift + 6'd2;
          end else begin
            norm_shift <= n_fin;
            x_work     <= u_ext + QUARTER;
            y_work     <= u_ext - QUARTER;
            state      <= ST_ROT;
          end
        end

        ST_ROT: begin
          if (shift_index <= {1'b0, iteration_count}) begin
            x_work <= x_rot;
            y_work <= y_rot;
            // A repeated index runs twice; the next repeat lies at 3k+1.
            if (shift_index == next_repeat) begin
              next_repeat <= rep_calc[5:0];
            end else begin
              shift_index <= shift_index + 6'd1;
            end
          end else begin
            state <= ST_SCALE;
          end
        end

        ST_SCALE: begin
          x_work <= x_work >>> norm_shift[5:1];
          state  <= ST_MUL;
        end

        ST_MUL: begin
          if (out_free) begin
            root_scaled  <= ROOT_W'(product);
            result_valid <= 1'b1;
            state        <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### tb/sv/tb_cordic_square_root_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cordic_square_root_unit
// Self-checking bench for the CORDIC square-root unit. A bit-exact predictor
// computes the scaled root of every accepted sample. A checker compares each
// result transfer with the oldest prediction. Directed extremes run first,
// then random samples under changing iteration counts and gain words. Both
// handshakes idle at random outside the no-idle random test.
// ----------------------------------------------------------------------------
module tb_cordic_square_root_unit;
  import csqrt_pkg::*;

  localparam int WIDTH       = 32;
  localparam int DRAIN_WAIT  = 60;
  localparam int IDLE_PCT    = 17;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       sample_valid = 1'b0;
  logic       sample_stall;
  sample_t    sample = '0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  root_t      root_scaled;
  logic       cfg_write = 1'b0;
  cfg_index_t cfg_index = REG_ITERATION_COUNT;
  cfg_data_t  cfg_data = '0;

  // Predictor copy of the configuration.
  count_t model_count = ITERATION_COUNT_RESET;
  gain_t  model_gain  = GAIN_WORD_RESET;

  root_t expected_roots[$];
  int    mismatch_count = 0;
  bit    idle_on = 1'b1;

  cordic_square_root_unit #(
    .WIDTH(WIDTH)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sample      (sample),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .root_scaled (root_scaled),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Scaled square root of one sample under the current configuration.
  function automatic root_t predict_root(sample_t value);
    longint x;
    longint y;
    longint xs;
    longint ys;
    longint prod;
    int     zeros;
    int     b;
    int     idx;
    int     repeat_at;
    if (value == '0) begin
      return '0;
    end
    zeros = 0;
    b = WIDTH - 1;
    while (b >= 0 && !value[b]) begin
      zeros++;
      b--;
    end
    // The shift is made even so that it can be halved when denormalizing.
    if (zeros > 1 && zeros[0]) begin
      zeros--;
    end
    if (zeros == 1) begin
      zeros = 2;
    end
    x = longint'(value) << zeros;
    y = x - (longint'(1) << (WIDTH - 2));
    x = x + (longint'(1) << (WIDTH - 2));
    idx = 1;
    repeat_at = 4;
    while (idx <= int'(model_count)) begin
      xs = x >>> idx;
      ys = y >>> idx;
      if (y < 0) begin
        x = x + ys;
        y = y + xs;
      end else begin
        x = x - ys;
        y = y - xs;
      end
      if (idx == repeat_at) begin
        repeat_at = 3 * idx + 1;
      end else begin
        idx++;
      end
    end
    xs = x >>> (zeros / 2);
    prod = xs * longint'(model_gain);
    return prod[ROOT_W-1:0];
  endfunction

  // Drives one sample and waits for its transfer. Valid stays high afterward
  // so that back-to-back samples need no second assignment in one step.
  task automatic send_sample(sample_t value);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample <= value;
    do @(posedge clk); while (sample_stall);
    expected_roots.push_back(predict_root(value));
  endtask

  // Lowers valid and waits until every predicted result has been checked.
  task automatic drain_results();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (expected_roots.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, cfg_data_t value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_ITERATION_COUNT) begin
      model_count = value[COUNT_W-1:0];
    end else begin
      model_gain = value[GAIN_W-1:0];
    end
    @(posedge clk);
  endtask

  task automatic set_config(count_t count, gain_t gain);
    write_reg(REG_ITERATION_COUNT, cfg_data_t'(count));
    write_reg(REG_GAIN_WORD, cfg_data_t'(gain));
  endtask

  // Spreads samples over all normalization shifts, with a few zeros and
  // full-scale values mixed in.
  function automatic sample_t random_sample();
    int pick;
    pick = $urandom_range(99);
    if (pick < 3) begin
      return '0;
    end else if (pick < 6) begin
      return '1;
    end
    return sample_t'($urandom) >> $urandom_range(WIDTH - 1);
  endfunction

  task automatic test_reset_config();
    sample_t values[$];
    values = '{32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
               32'hFFFF_FFFF, 32'h8000_0000, 32'h4000_0000, 32'h7FFF_FFFF,
               32'h0001_0000, 32'h0000_FFFF, 32'hAAAA_AAAA, 32'h5555_5555};
    foreach (values[i]) begin
      send_sample(values[i]);
    end
    drain_results();
  endtask

  task automatic test_config_extremes();
    set_config(count_t'(1), gain_t'(131071));
    send_sample(32'hFFFF_FFFF);
    send_sample(32'h0000_0001);
    send_sample(32'h1234_5678);
    drain_results();
    set_config(count_t'(31), gain_t'(0));
    send_sample(32'hFFFF_FFFF);
    send_sample(32'h0000_0005);
    send_sample(32'h0000_0000);
    drain_results();
    // A zero iteration count leaves x at its starting value.
    set_config(count_t'(0), GAIN_WORD_RESET);
    send_sample(32'h8000_0000);
    send_sample(32'h0000_0007);
    send_sample(32'hC000_0001);
    drain_results();
    set_config(count_t'(31), gain_t'(131071));
    send_sample(32'hFFFF_FFFF);
    send_sample(32'h0000_0001);
    send_sample(32'h2000_0000);
    drain_results();
  endtask

  task automatic test_random_no_idle();
    set_config(ITERATION_COUNT_RESET, GAIN_WORD_RESET);
    idle_on = 1'b0;
    repeat (100) send_sample(random_sample());
    drain_results();
    idle_on = 1'b1;
  endtask

  task automatic test_random_configs();
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: set_config(count_t'(31), gain_t'($urandom_range(131071)));
        1: set_config(count_t'(1), gain_t'(131071));
        2: set_config(count_t'($urandom_range(31, 1)), gain_t'(0));
        default: set_config(count_t'($urandom_range(31, 1)),
                            gain_t'($urandom_range(131071)));
      endcase
      repeat (50) send_sample(random_sample());
      drain_results();
    end
  endtask

  always @(posedge clk) begin
    if (idle_on) begin
      result_stall <= ($urandom_range(99) < IDLE_PCT);
    end else begin
      result_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    root_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_roots.size() == 0) begin
        $display("%0t: unexpected result transfer, expected none, actual %0h",
                 $time, root_scaled);
        mismatch_count++;
      end else begin
        want = expected_roots.pop_front();
        if (root_scaled !== want) begin
          $display("%0t: root_scaled mismatch, expected %0h, actual %0h",
                   $time, want, root_scaled);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_config();
    test_config_extremes();
    test_random_no_idle();
    test_random_configs();
    if (expected_roots.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_roots.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("%0t: timeout", $time);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

### cordic_square_root_unit.f
design/csqrt_pkg.sv
design/cordic_square_root_unit.sv
tb/sv/tb_cordic_square_root_unit.sv
